>>> hw/rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Types, constants and helpers for the restart segment deframer.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_GROUP  = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam logic CFG_SUBPACKET_LENGTH  = 1'b0;
  localparam logic CFG_HEADER_LAST_INDEX = 1'b1;

  localparam logic [7:0] SUBPACKET_LENGTH_RST  = 8'd20;
  localparam logic [3:0] HEADER_LAST_INDEX_RST = 4'd7;
  localparam logic [3:0] HEADER_LAST_MIN       = 4'd7;

  // Header byte positions
  localparam logic [11:0] POS_START_HI  = 12'd4;
  localparam logic [11:0] POS_START_LO  = 12'd5;
  localparam logic [11:0] POS_PKT_LEN   = 12'd6;
  localparam logic [11:0] POS_FRAME     = 12'd7;
  localparam logic [11:0] POS_MAX       = 12'd4095;

  localparam logic [7:0] SINGLE_SEG_FLAG = 8'h80;
  localparam logic [6:0] SEG_LEN_MASK    = 7'h7F;
  localparam logic [3:0] SEG_COUNT_MASK  = 4'hF;
  localparam logic [1:0] CHECKPOINT_BYTES = 2'd2;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Result queue depth
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  frame_number;
    logic [15:0] segment_number;
    logic [6:0]  segment_length;
    logic [7:0]  payload_byte;
    logic        last_in_segment;
  } result_t;

  function automatic result_t make_result(input logic kind, input logic [7:0] frame,
                                          input logic [15:0] seg, input logic [6:0] len,
                                          input logic [7:0] payload, input logic last);
    result_t r;
    r.kind            = kind;
    r.frame_number    = frame;
    r.segment_number  = seg;
    r.segment_length  = len;
    r.payload_byte    = payload;
    r.last_in_segment = last;
    return r;
  endfunction

endpackage

>>> hw/rtl/restart_segment_deframer.sv
// ----------------------------------------------------------------------------
// restart_segment_deframer
// Cuts a stream of packet bytes into restart segments: header and data results.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | in        | in_valid / in_stall | data_byte, packet_start
//  out      | out       | out_valid/out_stall | kind, frame_number, segment_number,
//           |           |                     | segment_length, payload_byte,
//           |           |                     | last_in_segment
//  cfg      | in        | write_enable        | write_index, write_data
//
// One byte is taken per cycle while in_stall is low; a byte lands in the
// input register, is parsed there, and its zero to two results enter a
// four-entry result queue once the queue has two free entries. The output
// side moves one result per cycle while out_stall is low. in_stall rises
// while the input register is full and the queue has fewer than two free
// entries. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module restart_segment_deframer
  import rsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        write_enable,
  input  logic        write_index,
  input  logic [7:0]  write_data,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  frame_number,
  output logic [15:0] segment_number,
  output logic [6:0]  segment_length,
  output logic [7:0]  payload_byte,
  output logic        last_in_segment
);

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = QAW + 1;

  // configuration
  logic [7:0]  subpacket_length;
  logic [3:0]  header_last_index;

  // input register
  logic        pipe_valid;
  logic [7:0]  pipe_byte;
  logic        pipe_start;

  // parse state
  phase_t      phase, phase_next;
  logic [11:0] byte_position, byte_position_next;
  logic [7:0]  subpacket_offset, subpacket_offset_next;
  logic [1:0]  checkpoint_skip, checkpoint_skip_next;
  logic [7:0]  packet_length, packet_length_next;
  logic [7:0]  frame_reg, frame_reg_next;
  logic [7:0]  start_high, start_high_next;
  logic [15:0] segment_counter, segment_counter_next;
  logic [3:0]  groups_left, groups_left_next;
  logic [6:0]  current_length, current_length_next;
  logic [6:0]  bytes_left, bytes_left_next;

  // result queue
  result_t     queue [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;

  logic        advance;
  logic        pop;
  logic [1:0]  push_n;
  result_t     res0, res1;

  logic [8:0]  off_inc;
  logic        cp_next;
  logic [3:0]  hdr_last;
  logic [3:0]  grp_count;
  logic [6:0]  grp_len;
  logic        last_data;

  assign advance  = pipe_valid && (count <= QCW'(QDEPTH - 2));
  assign in_stall = pipe_valid && !advance;
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  assign kind            = queue[rd_ptr].kind;
  assign frame_number    = queue[rd_ptr].frame_number;
  assign segment_number  = queue[rd_ptr].segment_number;
  assign segment_length  = queue[rd_ptr].segment_length;
  assign payload_byte    = queue[rd_ptr].payload_byte;
  assign last_in_segment = queue[rd_ptr].last_in_segment;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      subpacket_length  <= SUBPACKET_LENGTH_RST;
      header_last_index <= HEADER_LAST_INDEX_RST;
    end else if (write_enable) begin
      case (write_index)
        CFG_SUBPACKET_LENGTH:  subpacket_length  <= write_data;
        CFG_HEADER_LAST_INDEX: header_last_index <= write_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      pipe_valid <= 1'b1;
    end else if (advance) begin
      pipe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pipe_byte  <= data_byte;
      pipe_start <= packet_start;
    end
  end

  // Parse step for the byte in the input register
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    subpacket_offset_next = subpacket_offset;
    checkpoint_skip_next  = checkpoint_skip;
    packet_length_next    = packet_length;
    frame_reg_next        = frame_reg;
    start_high_next       = start_high;
    segment_counter_next  = segment_counter;
    groups_left_next      = groups_left;
    current_length_next   = current_length;
    bytes_left_next       = bytes_left;
    push_n                = 2'd0;
    res0                  = '0;
    res1                  = '0;
    off_inc               = 9'd0;
    cp_next               = 1'b0;
    hdr_last              = (header_last_index < HEADER_LAST_MIN) ? HEADER_LAST_MIN
                                                                 : header_last_index;
    grp_count             = 4'd0;
    grp_len               = 7'd0;
    last_data             = 1'b0;

    if (pipe_start) begin
      byte_position_next    = '0;
      subpacket_offset_next = '0;
      checkpoint_skip_next  = '0;
      groups_left_next      = '0;
      current_length_next   = '0;
      bytes_left_next       = '0;
      phase_next            = PH_HEADER;
    end

    if (phase_next != PH_IDLE && phase_next != PH_DONE) begin
      // offset within the sub-packet; a zero period means no checkpoints
      if (subpacket_length != '0) begin
        off_inc = {1'b0, subpacket_offset_next} + 9'd1;
        if (off_inc >= {1'b0, subpacket_length}) begin
          off_inc = 9'd0;
        end
        cp_next = (off_inc == 9'd0);
      end

      if (phase_next == PH_HEADER) begin
        case (byte_position_next)
          POS_START_HI: start_high_next      = pipe_byte;
          POS_START_LO: segment_counter_next = {start_high, pipe_byte};
          POS_PKT_LEN:  packet_length_next   = pipe_byte;
          POS_FRAME:    frame_reg_next       = pipe_byte;
          default: ;
        endcase
        if (byte_position_next >= {8'd0, hdr_last}) begin
          phase_next = PH_GROUP;
        end
      end else if (checkpoint_skip_next != '0) begin
        checkpoint_skip_next = checkpoint_skip_next - 2'd1;
      end else if (phase_next == PH_GROUP &&
                   byte_position_next >= {4'd0, packet_length_next}) begin
        // a group that would start at or past the packet length ends the packet
        phase_next = PH_DONE;
      end else if (phase_next == PH_GROUP) begin
        if ((pipe_byte & SINGLE_SEG_FLAG) != '0) begin
          grp_count = 4'd1;
          grp_len   = pipe_byte[6:0] & SEG_LEN_MASK;
        end else begin
          grp_count = pipe_byte[3:0] & SEG_COUNT_MASK;
          grp_len   = {3'd0, pipe_byte[7:4]} + 7'd1;
        end
        if (cp_next) begin
          checkpoint_skip_next = CHECKPOINT_BYTES;
        end
        if (grp_count != '0) begin
          current_length_next = grp_len;
          groups_left_next    = grp_count - 4'd1;
          push_n              = 2'd1;
          if (grp_len == '0) begin
            res0 = make_result(KIND_HEADER, frame_reg, segment_counter_next, grp_len,
                               8'd0, 1'b1);
            segment_counter_next = segment_counter_next + 16'd1;
          end else begin
            res0 = make_result(KIND_HEADER, frame_reg, segment_counter_next, grp_len,
                               8'd0, 1'b0);
            bytes_left_next = grp_len;
            phase_next      = PH_DATA;
          end
        end
      end else begin
        // data byte of the current segment
        last_data = (bytes_left_next <= 7'd1);
        push_n    = 2'd1;
        res0 = make_result(KIND_DATA, frame_reg, segment_counter_next, current_length_next,
                           pipe_byte, last_data);
        bytes_left_next = last_data ? 7'd0 : bytes_left_next - 7'd1;
        if (cp_next) begin
          checkpoint_skip_next = CHECKPOINT_BYTES;
        end
        if (last_data) begin
          segment_counter_next = segment_counter_next + 16'd1;
          if (groups_left_next != '0) begin
            groups_left_next = groups_left_next - 4'd1;
            bytes_left_next  = current_length_next;
            push_n           = 2'd2;
            res1 = make_result(KIND_HEADER, frame_reg, segment_counter_next,
                               current_length_next, 8'd0, current_length_next == '0);
            if (current_length_next == '0) begin
              segment_counter_next = segment_counter_next + 16'd1;
              phase_next           = PH_GROUP;
            end
          end else begin
            phase_next = PH_GROUP;
          end
        end
      end

      // hold position and offset once the packet is over
      if (phase_next != PH_DONE) begin
        if (byte_position_next < POS_MAX) begin
          byte_position_next = byte_position_next + 12'd1;
        end
        subpacket_offset_next = off_inc[7:0];
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_position    <= '0;
      subpacket_offset <= '0;
      checkpoint_skip  <= '0;
      packet_length    <= '0;
      frame_reg        <= '0;
      start_high       <= '0;
      segment_counter  <= '0;
      groups_left      <= '0;
      current_length   <= '0;
      bytes_left       <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      subpacket_offset <= subpacket_offset_next;
      checkpoint_skip  <= checkpoint_skip_next;
      packet_length    <= packet_length_next;
      frame_reg        <= frame_reg_next;
      start_high       <= start_high_next;
      segment_counter  <= segment_counter_next;
      groups_left      <= groups_left_next;
      current_length   <= current_length_next;
      bytes_left       <= bytes_left_next;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (advance && push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (advance && push_n == 2'd2) begin
      queue[wr_ptr + QAW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + QAW'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (advance ? QCW'(push_n) : QCW'(0)) - QCW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_data_phase_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) == (bytes_left != '0))
    else $error("bytes_left out of step with data phase");

  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    checkpoint_skip != '0 |-> (checkpoint_skip <= CHECKPOINT_BYTES) &&
                              (phase == PH_GROUP || phase == PH_DATA))
    else $error("checkpoint skip outside group or data phase");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_DONE) && advance && !pipe_start |=>
      $stable(wr_ptr))
    else $error("result produced outside a packet");
`endif

endmodule

>>> sim/tb_restart_segment_deframer.sv
// ----------------------------------------------------------------------------
// tb_restart_segment_deframer
// Self-checking bench for the restart segment deframer. Packet byte streams
// (headers, group bytes, segment data, checkpoint bytes, stray and broken
// packets) are pushed through under random source gaps and sink stalls; a
// behavioural predictor works out every segment header and data result, and
// each result leaving the block is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_restart_segment_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import rsd_pkg::*;

  localparam int TX_ITEMS     = 900;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 4;
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        write_enable = 1'b0;
  logic        write_index  = CFG_SUBPACKET_LENGTH;
  logic [7:0]  write_data   = 8'd0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte    = 8'd0;
  logic        packet_start = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        kind;
  logic [7:0]  frame_number;
  logic [15:0] segment_number;
  logic [6:0]  segment_length;
  logic [7:0]  payload_byte;
  logic        last_in_segment;

  // predictor state, mirrors the block after reset
  logic [7:0]  period_cfg   = SUBPACKET_LENGTH_RST;
  logic [3:0]  hdr_last_cfg = HEADER_LAST_INDEX_RST;
  logic [11:0] pos_q        = '0;
  logic [7:0]  sub_off      = '0;
  logic [1:0]  cp_left      = '0;
  logic [7:0]  pkt_len_q    = '0;
  logic [7:0]  frame_q      = '0;
  logic [7:0]  start_hi_q   = '0;
  logic [15:0] seg_num_q    = '0;
  phase_t      parse_state  = PH_IDLE;
  logic [3:0]  segs_left    = '0;
  logic [6:0]  seg_len_q    = '0;
  logic [6:0]  data_left    = '0;

  result_t expected_results[$];

  int  errors          = 0;
  int  bytes_sent      = 0;
  int  packets_sent    = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  bit  tx_idle_en      = 1'b1;
  bit  rx_idle_en      = 1'b1;
  bit  hold_request    = 1'b0;

  restart_segment_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .packet_start   (packet_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .frame_number   (frame_number),
    .segment_number (segment_number),
    .segment_length (segment_length),
    .payload_byte   (payload_byte),
    .last_in_segment(last_in_segment)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void queue_result(logic k, logic [7:0] payload, logic last);
    result_t r;
    r.kind            = k;
    r.frame_number    = frame_q;
    r.segment_number  = seg_num_q;
    r.segment_length  = seg_len_q;
    r.payload_byte    = payload;
    r.last_in_segment = last;
    expected_results.push_back(r);
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic first);
    logic [8:0] off_inc;
    logic [7:0] off_next;
    logic       at_checkpoint;
    logic [3:0] hdr_end;
    logic [3:0] count;
    logic [6:0] len;
    logic       seg_done;
    if (first) begin
      pos_q       = '0;
      sub_off     = '0;
      cp_left     = '0;
      segs_left   = '0;
      seg_len_q   = '0;
      data_left   = '0;
      parse_state = PH_HEADER;
    end
    if (parse_state == PH_IDLE || parse_state == PH_DONE) return;

    off_inc = {1'b0, sub_off} + 9'd1;
    if (period_cfg == 8'd0) begin
      off_next      = 8'd0;
      at_checkpoint = 1'b0;
    end else begin
      // a lowered period wraps the offset as soon as it is reached or passed
      off_next      = (off_inc >= {1'b0, period_cfg}) ? 8'd0 : off_inc[7:0];
      at_checkpoint = (off_next == 8'd0);
    end
    hdr_end = (hdr_last_cfg < HEADER_LAST_MIN) ? HEADER_LAST_MIN : hdr_last_cfg;

    if (parse_state == PH_HEADER) begin
      case (pos_q)
        POS_START_HI: start_hi_q = b;
        POS_START_LO: seg_num_q  = {start_hi_q, b};
        POS_PKT_LEN:  pkt_len_q  = b;
        POS_FRAME:    frame_q    = b;
        default: ;
      endcase
      if (pos_q >= 12'(hdr_end)) parse_state = PH_GROUP;
    end else if (cp_left != 2'd0) begin
      cp_left = cp_left - 2'd1;
    end else if (parse_state == PH_GROUP) begin
      // no group may start at or past the packet length: drop the rest
      if (pos_q >= 12'(pkt_len_q)) begin
        parse_state = PH_DONE;
        return;
      end
      if ((b & SINGLE_SEG_FLAG) != 8'd0) begin
        count = 4'd1;
        len   = b[6:0] & SEG_LEN_MASK;
      end else begin
        count = b[3:0] & SEG_COUNT_MASK;
        len   = 7'(b[7:4]) + 7'd1;
      end
      if (at_checkpoint) cp_left = CHECKPOINT_BYTES;
      if (count != 4'd0) begin
        seg_len_q = len;
        segs_left = count - 4'd1;
        if (len == 7'd0) begin
          queue_result(KIND_HEADER, 8'd0, 1'b1);
          seg_num_q = seg_num_q + 16'd1;
        end else begin
          queue_result(KIND_HEADER, 8'd0, 1'b0);
          data_left   = len;
          parse_state = PH_DATA;
        end
      end
    end else begin
      seg_done = (data_left <= 7'd1);
      queue_result(KIND_DATA, b, seg_done);
      data_left = seg_done ? 7'd0 : data_left - 7'd1;
      if (at_checkpoint) cp_left = CHECKPOINT_BYTES;
      if (seg_done) begin
        seg_num_q = seg_num_q + 16'd1;
        if (segs_left != 4'd0) begin
          segs_left = segs_left - 4'd1;
          data_left = seg_len_q;
          queue_result(KIND_HEADER, 8'd0, seg_len_q == 7'd0);
          if (seg_len_q == 7'd0) begin
            seg_num_q   = seg_num_q + 16'd1;
            parse_state = PH_GROUP;
          end
        end else begin
          parse_state = PH_GROUP;
        end
      end
    end

    if (pos_q != POS_MAX) pos_q = pos_q + 12'd1;
    sub_off = off_next;
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void compare_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0b segment %0h",
                 $time, kind, segment_number);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", 16'(want.kind), 16'(kind));
        compare_field("frame_number", 16'(want.frame_number), 16'(frame_number));
        compare_field("segment_number", want.segment_number, segment_number);
        compare_field("segment_length", 16'(want.segment_length), 16'(segment_length));
        compare_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
        compare_field("last_in_segment", 16'(want.last_in_segment), 16'(last_in_segment));
        results_checked++;
      end
    end
  end

  // sink: random stalls, or one long hold when asked
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= rx_idle_en && ($urandom_range(99) < 31);
    end
  end

  // ---------------------------------------------------------------- drivers
  // entered and left at a falling edge; hold each request until taken
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (tx_idle_en && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    packet_start <= first;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    deframe_byte(b, first);
    bytes_sent++;
    if (first) packets_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    // a byte with no result may still be in flight
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
    if (idx == CFG_SUBPACKET_LENGTH) period_cfg = value;
    else hdr_last_cfg = value[3:0];
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [7:0] period, input logic [3:0] hdr_last);
    wait_idle();
    write_reg(CFG_SUBPACKET_LENGTH, period);
    write_reg(CFG_HEADER_LAST_INDEX, {4'd0, hdr_last});
  endtask

  function automatic logic [7:0] pick_group_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return {1'b0, 3'($urandom_range(3)), 4'($urandom_range(1, 4))};
    if (roll < 70) return SINGLE_SEG_FLAG | 8'($urandom_range(12));
    if (roll < 78) return SINGLE_SEG_FLAG | 8'($urandom_range(127));
    if (roll < 88) return {1'b0, 3'($urandom), 4'h0};
    return 8'($urandom);
  endfunction

  task automatic send_header(input logic [7:0] plen);
    logic near_wrap;
    near_wrap = ($urandom_range(9) == 0);
    send_byte(8'($urandom), 1'b1);
    while (parse_state == PH_HEADER) begin
      case (pos_q)
        POS_START_HI: send_byte(near_wrap ? 8'hFF : 8'($urandom), 1'b0);
        POS_START_LO: send_byte(near_wrap ? 8'($urandom_range(240, 255)) : 8'($urandom), 1'b0);
        POS_PKT_LEN:  send_byte(plen, 1'b0);
        default:      send_byte(8'($urandom), 1'b0);
      endcase
    end
  endtask

  // follow the parser: group bytes where a group is due, anything elsewhere
  task automatic send_body(input int max_bytes);
    for (int i = 0; i < max_bytes && parse_state != PH_DONE; i++) begin
      if (parse_state == PH_GROUP && cp_left == 2'd0) send_byte(pick_group_byte(), 1'b0);
      else send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic send_packet();
    int unsigned roll;
    logic [7:0]  plen;
    roll = $urandom_range(9);
    if (roll == 0) plen = 8'hFF;
    else if (roll == 1) plen = 8'($urandom_range(12));
    else plen = 8'($urandom_range(10, 60));
    send_header(plen);
    // now and then cut the packet short
    send_body(($urandom_range(9) == 0) ? int'($urandom_range(1, 10)) : 300);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom), $urandom_range(19) == 0);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_bytes_before_start();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);
    wait_idle();
  endtask

  task automatic test_basic_packet();
    logic [7:0] seq [19];
    // start number 0x1234, length 48, frame 0xA5; then a three-byte segment,
    // a zero-count group, an empty segment and a group of two two-byte segments
    seq = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h12, 8'h34, 8'd48, 8'hA5,
            8'h83, 8'h00, 8'hFF, 8'h7E, 8'h20, 8'h80,
            8'h12, 8'h01, 8'h02, 8'h03, 8'h04};
    foreach (seq[i]) send_byte(seq[i], i == 0);
    wait_idle();
  endtask

  task automatic test_short_packet();
    logic [7:0] seq [13];
    // length 9: the segment data runs past it, the next group ends the packet
    seq = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd9, 8'h3C,
            8'h82, 8'hC3, 8'h3C, 8'hF1, 8'h81};
    foreach (seq[i]) send_byte(seq[i], i == 0);
    wait_idle();
  endtask

  task automatic test_register_settings();
    apply_settings(8'd4, 4'd7);
    send_packet();
    apply_settings(8'd255, 4'd15);
    send_packet();
    apply_settings(8'd0, 4'd3);
    send_packet();
    apply_settings(8'd1, 4'd7);
    send_packet();
    apply_settings(8'd2, 4'd0);
    send_packet();
    apply_settings(8'd3, 4'd10);
    send_packet();
    wait_idle();
  endtask

  task automatic test_period_change();
    apply_settings(8'd40, 4'd7);
    send_header(8'd200);
    send_body(25);
    // shrink the period below the running offset, then widen it again
    wait_idle();
    write_reg(CFG_SUBPACKET_LENGTH, 8'd5);
    send_body(25);
    wait_idle();
    write_reg(CFG_SUBPACKET_LENGTH, 8'd255);
    send_body(40);
    wait_idle();
  endtask

  task automatic test_backpressure();
    apply_settings(SUBPACKET_LENGTH_RST, HEADER_LAST_INDEX_RST);
    hold_request = 1'b1;
    send_header(8'd120);
    send_body(60);
    wait_idle();
  endtask

  task automatic test_no_idle();
    int first_byte;
    first_byte = bytes_sent;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (bytes_sent - first_byte < 150) send_packet();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_stream();
    logic [7:0] period;
    do begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(5))
          0:       period = 8'd0;
          1:       period = 8'($urandom_range(1, 3));
          2:       period = 8'd255;
          default: period = 8'($urandom_range(4, 40));
        endcase
        apply_settings(period, 4'($urandom_range(15)));
      end
      if ($urandom_range(9) == 0) send_noise($urandom_range(3, 12));
      send_packet();
    end while (bytes_sent < TX_ITEMS);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_bytes_before_start();
    test_basic_packet();
    test_short_packet();
    test_register_settings();
    test_period_change();
    test_backpressure();
    test_no_idle();
    test_random_stream();

    in_valid <= 1'b0;
    for (int n = 0; n < 5000 && expected_results.size() != 0; n++) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: missing results: expected %0d more, got none", $time,
               expected_results.size());
      errors++;
    end
    repeat (10) @(negedge clk);

    $display("Covered %0d bytes in %0d packets, %0d results checked, %0d register writes",
             bytes_sent, packets_sent, results_checked, reg_writes);
    $display("Periods 0 to 255, header ends 0 to 15, stalls, gaps and a long sink hold");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
